// ===== sv/pinned_round_robin_task_picker_assert.svh =====
// Assertion macros used by the task picker checker.
`ifndef PINNED_ROUND_ROBIN_TASK_PICKER_ASSERT_SVH
`define PINNED_ROUND_ROBIN_TASK_PICKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst is high.
`define PRRTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst is high.
`define PRRTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/prrtp_pkg.sv =====
// Shared types and constants of the pinned round-robin task picker.
package prrtp_pkg;

   localparam int TABLE_SLOTS_DEF = 64;

   localparam int CMD_W   = 2;
   localparam int SLOT_W  = 6;
   localparam int CORE_W  = 4;
   localparam int PTR_W   = 64;
   localparam int TOTAL_W = 7;
   localparam int TICK_W  = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CORE_ID = CSR_IDX_W'(0);

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [SLOT_W-1:0]  slot;
      logic               runnable;
      logic [CORE_W-1:0]  owner_core;
      logic [PTR_W-1:0]   pointer_value;
      logic [TOTAL_W-1:0] slot_total;
   } req_type;

   typedef struct packed {
      logic [PTR_W-1:0]  next_stack;
      logic              task_chosen;
      logic [SLOT_W-1:0] chosen_slot;
      logic [TICK_W-1:0] tick_total;
   } rsp_type;

endpackage

// ===== sv/prrtp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prrtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pinned_round_robin_task_picker.sv =====
// Pinned round-robin task picker: task table, tick handling and result register.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data) carries commands: write a
//    table slot, set the number of slots in use, or a timer tick.
//  - rsp channel (rsp_valid / rsp_stall / rsp_data) returns one transfer per
//    tick: the stack to resume, whether a task was picked, its slot, tick count.
//  - APB-style port holds core_id at byte address 0, to be written only while idle (the block does not enforce it).
// Operation:
//  - slot write and slot count commands complete while idle, with no result.
//  - a tick is accepted, then a shift-subtract unit finds the scan start
//    (scan+1) mod count in CNT_W restoring steps, then the table slots are
//    read (pipelined through the table RAMs, one read per cycle) until a hit
//    or the last slot's registered RAM data is checked, then the result goes
//    into the output register once it is free; a count of zero skips the scan.
//  - req_stall is high from a tick's transfer until its result is loaded.
// Reset clears the runnable flags, count, current task, idle stack, scan
// position, tick count and core_id; no clearing pass is needed.
// While rsp_stall holds a result, the next tick finishes into a holding
// register and waits there, holding off slot and count commands until it leaves.
module pinned_round_robin_task_picker #(
   parameter int TABLE_SLOTS = prrtp_pkg::TABLE_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  prrtp_pkg::req_type                  req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output prrtp_pkg::rsp_type                  rsp_data,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [prrtp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [prrtp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [prrtp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   // Slot index width and slot count width (count may equal TABLE_SLOTS).
   localparam int IDX_W  = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int STEP_W = $clog2(CNT_W);
   localparam int DIV_W  = 2 * CNT_W;

   // ---------------------------------------------------------------- state
   prrtp_pkg::state_type state_ff, state_in;

   logic [TABLE_SLOTS-1:0]        runnable_ff, runnable_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          cur_vld_ff, cur_vld_in;
   logic [IDX_W-1:0]              cur_slot_ff, cur_slot_in;
   logic [prrtp_pkg::PTR_W-1:0]   idle_stack_ff, idle_stack_in;
   logic [IDX_W-1:0]              scan_ff, scan_in;
   logic [prrtp_pkg::TICK_W-1:0]  tick_ff, tick_in;
   logic [prrtp_pkg::CORE_W-1:0]  core_id_ff, core_id_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          chk_vld_ff, chk_vld_in;

   // Working registers of a tick (no reset needed).
   logic [CNT_W-1:0]              rem_ff, rem_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              issue_cnt_ff, issue_cnt_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic                          chk_last_ff, chk_last_in;
   prrtp_pkg::rsp_type            res_ff, res_in;
   prrtp_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- table RAMs
   logic                          ram_we;
   logic                          owner_we;
   logic [IDX_W-1:0]              ram_waddr;
   logic [prrtp_pkg::CORE_W-1:0]  owner_rd;
   logic [prrtp_pkg::PTR_W-1:0]   stack_rd;

   prrtp_ram #(
      .WIDTH (prrtp_pkg::CORE_W),
      .DEPTH (TABLE_SLOTS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.owner_core),
      .rd_addr (idx_ff),
      .rd_data (owner_rd)
   );

   // Stack RAM: written by slot writes and by the save on a tick.
   prrtp_ram #(
      .WIDTH (prrtp_pkg::PTR_W),
      .DEPTH (TABLE_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.pointer_value),
      .rd_addr (idx_ff),
      .rd_data (stack_rd)
   );

   // ---------------------------------------------------------------- handshake
   logic req_fire;
   logic rsp_free;
   logic csr_wr;
   logic csr_hit;

   assign req_stall = (state_ff != prrtp_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[prrtp_pkg::CSR_ADDR_W-1:2] == prrtp_pkg::CSR_CORE_ID);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;
   assign prdata  = csr_hit ? prrtp_pkg::CSR_DATA_W'(core_id_ff) : '0;

   // ---------------------------------------------------------------- scan checks
   // Remainder unit: one restoring step per cycle on the shifted count.
   logic [DIV_W-1:0] div_shifted;
   logic             div_ge;
   logic [CNT_W-1:0] rem_step;

   assign div_shifted = DIV_W'(cnt_ff) << step_ff;
   assign div_ge      = (DIV_W'(rem_ff) >= div_shifted);
   assign rem_step    = div_ge ? (rem_ff - CNT_W'(div_shifted)) : rem_ff;

   // RAM data belongs to chk_idx_ff, read in the cycle before.
   logic hit;
   logic scan_miss;
   logic issue;

   assign hit = chk_vld_ff && runnable_ff[chk_idx_ff]
             && (owner_rd == core_id_ff) && (stack_rd != '0);
   assign scan_miss = chk_vld_ff && chk_last_ff && !hit;
   assign issue     = (issue_cnt_ff != cnt_ff);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prrtp_pkg::ST_IDLE: begin
            if (req_fire && (req_data.cmd == prrtp_pkg::CMD_TICK)) begin
               state_in = prrtp_pkg::ST_MOD;
            end
         end
         prrtp_pkg::ST_MOD: begin
            if (cnt_ff == '0) begin
               state_in = prrtp_pkg::ST_DONE;
            end else if (step_ff == '0) begin
               state_in = prrtp_pkg::ST_SCAN;
            end
         end
         prrtp_pkg::ST_SCAN: begin
            if (hit || scan_miss) begin
               state_in = prrtp_pkg::ST_DONE;
            end
         end
         prrtp_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = prrtp_pkg::ST_IDLE;
            end
         end
         default: state_in = prrtp_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      runnable_in   = runnable_ff;
      cnt_in        = cnt_ff;
      cur_vld_in    = cur_vld_ff;
      cur_slot_in   = cur_slot_ff;
      idle_stack_in = idle_stack_ff;
      scan_in       = scan_ff;
      tick_in       = tick_ff;
      core_id_in    = core_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      chk_vld_in    = chk_vld_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_idx_in    = chk_idx_ff;
      chk_last_in   = chk_last_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      owner_we      = 1'b0;
      ram_waddr     = cur_slot_ff;

      if (csr_wr) begin
         core_id_in = pwdata[prrtp_pkg::CORE_W-1:0];
      end

      // a waiting result leaves on its transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         prrtp_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.cmd)
                  prrtp_pkg::CMD_WRITE: begin
                     // writes beyond the table are dropped
                     if (32'(req_data.slot) < TABLE_SLOTS) begin
                        ram_we      = 1'b1;
                        owner_we    = 1'b1;
                        ram_waddr   = IDX_W'(req_data.slot);
                        runnable_in[IDX_W'(req_data.slot)] = req_data.runnable;
                     end
                  end
                  prrtp_pkg::CMD_COUNT: begin
                     if (32'(req_data.slot_total) > TABLE_SLOTS) begin
                        cnt_in = CNT_W'(TABLE_SLOTS);
                     end else begin
                        cnt_in = CNT_W'(req_data.slot_total);
                     end
                  end
                  prrtp_pkg::CMD_TICK: begin
                     tick_in = tick_ff + prrtp_pkg::TICK_W'(1);
                     // save the interrupted stack
                     if (cur_vld_ff) begin
                        ram_we = 1'b1;
                     end else begin
                        idle_stack_in = req_data.pointer_value;
                     end
                     rem_in  = CNT_W'(scan_ff) + CNT_W'(1);
                     step_in = STEP_W'(CNT_W - 1);
                  end
                  default: ;
               endcase
            end
         end

         prrtp_pkg::ST_MOD: begin
            if (cnt_ff == '0) begin
               cur_vld_in         = 1'b0;
               res_in.next_stack  = idle_stack_ff;
               res_in.task_chosen = 1'b0;
               res_in.chosen_slot = '0;
               res_in.tick_total  = tick_ff;
            end else begin
               rem_in  = rem_step;
               step_in = step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  idx_in       = IDX_W'(rem_step);
                  issue_cnt_in = '0;
                  chk_vld_in   = 1'b0;
               end
            end
         end

         prrtp_pkg::ST_SCAN: begin
            if (hit) begin
               scan_in            = chk_idx_ff;
               cur_vld_in         = 1'b1;
               cur_slot_in        = chk_idx_ff;
               chk_vld_in         = 1'b0;
               res_in.next_stack  = stack_rd;
               res_in.task_chosen = 1'b1;
               res_in.chosen_slot = prrtp_pkg::SLOT_W'(chk_idx_ff);
               res_in.tick_total  = tick_ff;
            end else if (scan_miss) begin
               cur_vld_in         = 1'b0;
               chk_vld_in         = 1'b0;
               res_in.next_stack  = idle_stack_ff;
               res_in.task_chosen = 1'b0;
               res_in.chosen_slot = '0;
               res_in.tick_total  = tick_ff;
            end else begin
               // one table read per cycle, wrapping at the slot count
               chk_vld_in  = issue;
               chk_idx_in  = idx_ff;
               chk_last_in = (issue_cnt_ff == (cnt_ff - CNT_W'(1)));
               if (issue) begin
                  issue_cnt_in = issue_cnt_ff + CNT_W'(1);
                  if ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff) begin
                     idx_in = '0;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
         end

         prrtp_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end

         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prrtp_pkg::ST_IDLE;
         runnable_ff   <= '0;
         cnt_ff        <= '0;
         cur_vld_ff    <= 1'b0;
         cur_slot_ff   <= '0;
         idle_stack_ff <= '0;
         scan_ff       <= '0;
         tick_ff       <= '0;
         core_id_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         chk_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         runnable_ff   <= runnable_in;
         cnt_ff        <= cnt_in;
         cur_vld_ff    <= cur_vld_in;
         cur_slot_ff   <= cur_slot_in;
         idle_stack_ff <= idle_stack_in;
         scan_ff       <= scan_in;
         tick_ff       <= tick_in;
         core_id_ff    <= core_id_in;
         rsp_valid_ff  <= rsp_valid_in;
         chk_vld_ff    <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      issue_cnt_ff <= issue_cnt_in;
      chk_idx_ff   <= chk_idx_in;
      chk_last_ff  <= chk_last_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/prrtp_checker.sv =====
// Port-level checker of the task picker and its bind.
`include "pinned_round_robin_task_picker_assert.svh"

module prrtp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input prrtp_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input prrtp_pkg::rsp_type rsp_data
);

   // after reset nothing is pending and commands are taken
   `PRRTP_ASSERT_NEXT(a_reset_clean, clock, 1'b0, reset, !rsp_valid && !req_stall, "not idle after reset")

   // slot and count commands finish in their own cycle
   `PRRTP_ASSERT_NEXT(a_cmd_single, clock, reset, req_valid && !req_stall && (req_data.cmd != prrtp_pkg::CMD_TICK), !req_stall, "non-tick command held the input")

   // idle picks report slot zero
   `PRRTP_ASSERT_NOW(a_idle_slot, clock, reset, rsp_valid && !rsp_data.task_chosen, rsp_data.chosen_slot == '0, "idle pick with nonzero slot")

   `PRRTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   `PRRTP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "result changed while stalled")

endmodule

bind pinned_round_robin_task_picker prrtp_checker u_prrtp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
